// ===== src/fstm_pkg.sv =====
package fstm_pkg;

    localparam int unsigned WINDOW_DEFAULT = 64;
    localparam logic [31:0] PERIOD_RESET   = 32'd16666667;

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_SNAP   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [47:0] MAX48 = {48{1'b1}};
    localparam logic [55:0] MAX56 = {56{1'b1}};
    localparam logic [62:0] MAX63 = {63{1'b1}};
    localparam logic [23:0] RATE_MAX = {24{1'b1}};

    // One billion times 256: the Q8 scaling that turns steps per nanosecond into steps per second.
    localparam logic [39:0] RATE_SCALE = 40'd256000000000;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

endpackage

// ===== src/fstm_ram.sv =====
module fstm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/fstm_div.sv =====
module fstm_div
    import fstm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [63:0] quo_reg, quo_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[63]} - {1'b0, dvs_reg};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[64]) begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = {rem_reg[62:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== src/fixed_step_timing_monitor.sv =====
// Fixed-step timing monitor. One request is taken at a time and answered with one snapshot.
// After a request is taken the window ring memories are walked in order. An entry with steps
// also has its per-step time divided in one shared radix-2 divider, while an entry without
// steps is only read and summed. The average, the step rate and the latest per-step time then
// need three more divisions before the snapshot is offered. A new request is taken only once
// the previous snapshot has left the output register, or in the cycle in which it leaves.
module fixed_step_timing_monitor
    import fstm_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [31:0] s_frame_ns,
    input  logic [31:0] s_simulation_ns,
    input  logic [31:0] s_discarded_ns,
    input  logic [7:0]  s_step_count,
    input  logic        s_limit_hit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [$clog2(WINDOW+1)-1:0] m_window_fill,
    output logic [47:0] m_frames_total,
    output logic [55:0] m_steps_total,
    output logic [47:0] m_catch_up_frames,
    output logic [47:0] m_limit_hits,
    output logic [47:0] m_deadline_misses,
    output logic        m_last_missed,
    output logic [31:0] m_last_step_ns,
    output logic [31:0] m_max_step_ns,
    output logic [31:0] m_avg_step_ns,
    output logic [23:0] m_step_rate_q8,
    output logic [62:0] m_discarded_total_ns
);

    localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned FW = $clog2(WINDOW + 1);
    localparam int unsigned RD = (WINDOW > 1) ? WINDOW : 2;

    typedef enum logic [3:0] {
        IDLE, WALK, WALK_LAST, ENT_DIV, ENT_WAIT, AVG_WAIT, RATE_WAIT, LAST_WAIT, OUT
    } state_t;

    state_t      state_reg;
    logic [31:0] period_reg;
    logic [AW-1:0] wp_reg;
    logic [FW-1:0] fill_reg;
    logic [47:0] frames_reg, catch_reg, limit_reg, miss_reg;
    logic [55:0] steps_reg;
    logic        flag_reg;
    logic [62:0] disc_reg;
    logic [31:0] lsim_reg;
    logic [7:0]  lsteps_reg;
    logic [FW-1:0] idx_reg;
    logic [41:0] sum_frame_reg, sum_sim_reg;
    logic [17:0] sum_steps_reg;
    logic [31:0] max_reg, avg_reg, last_reg;
    logic [23:0] rate_reg;
    logic [31:0] cur_sim_reg;
    logic [7:0]  cur_steps_reg;
    logic        cur_chk_reg;
    logic [57:0] rate_num_reg;
    logic        out_valid_reg;
    logic [FW-1:0] o_fill_reg;
    logic [47:0] o_frames_reg, o_catch_reg, o_limit_reg, o_miss_reg;
    logic [55:0] o_steps_reg;
    logic        o_flag_reg;
    logic [62:0] o_disc_reg;
    logic [31:0] o_last_reg, o_max_reg, o_avg_reg;
    logic [23:0] o_rate_reg;

    logic        ram_we;
    logic [AW-1:0] rd_addr;
    logic [31:0] rd_frame, rd_sim;
    logic [7:0]  rd_steps;
    div_req_t    dreq;
    div_rsp_t    drsp;
    logic        accept;
    logic [39:0] budget;
    logic        miss_now;
    logic [56:0] steps_sum;
    logic [63:0] disc_sum;

    assign s_ready = (state_reg == IDLE) && (!out_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign ram_we  = accept && (s_operation == OP_RECORD);
    assign rd_addr = idx_reg[AW-1:0];

    fstm_ram #(.WIDTH(32), .DEPTH(RD)) u_ram_frame (
        .aclk(aclk), .wr_en(ram_we), .wr_addr(wp_reg), .wr_data(s_frame_ns),
        .rd_addr(rd_addr), .rd_data(rd_frame)
    );
    fstm_ram #(.WIDTH(32), .DEPTH(RD)) u_ram_sim (
        .aclk(aclk), .wr_en(ram_we), .wr_addr(wp_reg), .wr_data(s_simulation_ns),
        .rd_addr(rd_addr), .rd_data(rd_sim)
    );
    fstm_ram #(.WIDTH(8), .DEPTH(RD)) u_ram_steps (
        .aclk(aclk), .wr_en(ram_we), .wr_addr(wp_reg), .wr_data(s_step_count),
        .rd_addr(rd_addr), .rd_data(rd_steps)
    );

    fstm_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    assign budget    = {8'd0, period_reg} * {32'd0, s_step_count};
    assign miss_now  = (s_step_count != 8'd0) && ({8'd0, s_simulation_ns} > budget);
    assign steps_sum = {1'b0, steps_reg} + {49'd0, s_step_count};
    assign disc_sum  = {1'b0, disc_reg} + {32'd0, s_discarded_ns};

    always_comb begin
        dreq = '0;
        unique case (state_reg)
            ENT_DIV: begin
                dreq.start    = 1'b1;
                dreq.dividend = {32'd0, cur_sim_reg};
                dreq.divisor  = {56'd0, cur_steps_reg};
            end
            ENT_WAIT: begin
                if ((idx_reg == fill_reg) && (!cur_chk_reg || drsp.done)) begin
                    dreq.start    = 1'b1;
                    dreq.dividend = {22'd0, sum_sim_reg};
                    dreq.divisor  = {46'd0, sum_steps_reg};
                end
            end
            AVG_WAIT: begin
                if (drsp.done) begin
                    dreq.start    = 1'b1;
                    dreq.dividend = {6'd0, rate_num_reg};
                    dreq.divisor  = {22'd0, sum_frame_reg};
                end
            end
            RATE_WAIT: begin
                if (drsp.done) begin
                    dreq.start    = 1'b1;
                    dreq.dividend = {32'd0, lsim_reg};
                    dreq.divisor  = {56'd0, lsteps_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            period_reg    <= PERIOD_RESET;
            wp_reg        <= '0;
            fill_reg      <= '0;
            frames_reg    <= '0;
            steps_reg     <= '0;
            catch_reg     <= '0;
            limit_reg     <= '0;
            miss_reg      <= '0;
            flag_reg      <= 1'b0;
            disc_reg      <= '0;
            lsim_reg      <= '0;
            lsteps_reg    <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            cur_chk_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                period_reg <= cfg_wr_data;
            end
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (accept) begin
                        if (s_operation == OP_RECORD) begin
                            wp_reg <= (wp_reg == AW'(WINDOW - 1)) ? '0 : wp_reg + AW'(1);
                            if (fill_reg != FW'(WINDOW)) begin
                                fill_reg <= fill_reg + FW'(1);
                            end
                            lsim_reg   <= s_simulation_ns;
                            lsteps_reg <= s_step_count;
                            frames_reg <= (frames_reg == MAX48) ? MAX48 : frames_reg + 48'd1;
                            steps_reg  <= steps_sum[56] ? MAX56 : steps_sum[55:0];
                            if (s_step_count > 8'd1 && catch_reg != MAX48) begin
                                catch_reg <= catch_reg + 48'd1;
                            end
                            if (s_limit_hit && limit_reg != MAX48) begin
                                limit_reg <= limit_reg + 48'd1;
                            end
                            flag_reg <= miss_now;
                            if (miss_now && miss_reg != MAX48) begin
                                miss_reg <= miss_reg + 48'd1;
                            end
                            disc_reg <= (disc_sum[63] || disc_sum[62:0] == MAX63) ?
                                MAX63 : disc_sum[62:0];
                        end else if (s_operation == OP_CLEAR) begin
                            wp_reg     <= '0;
                            fill_reg   <= '0;
                            frames_reg <= '0;
                            steps_reg  <= '0;
                            catch_reg  <= '0;
                            limit_reg  <= '0;
                            miss_reg   <= '0;
                            flag_reg   <= 1'b0;
                            disc_reg   <= '0;
                            lsim_reg   <= '0;
                            lsteps_reg <= '0;
                        end
                        idx_reg       <= '0;
                        sum_frame_reg <= '0;
                        sum_sim_reg   <= '0;
                        sum_steps_reg <= '0;
                        max_reg       <= '0;
                        state_reg     <= WALK;
                    end
                end
                WALK: begin
                    // Read address is issued here; data appears in WALK_LAST.
                    if (idx_reg == fill_reg) begin
                        state_reg <= ENT_WAIT;
                        cur_chk_reg <= 1'b0;
                    end else begin
                        state_reg <= WALK_LAST;
                    end
                end
                WALK_LAST: begin
                    sum_frame_reg <= sum_frame_reg + {10'd0, rd_frame};
                    sum_steps_reg <= sum_steps_reg + {10'd0, rd_steps};
                    if (rd_steps != 8'd0) begin
                        sum_sim_reg <= sum_sim_reg + {10'd0, rd_sim};
                    end
                    cur_sim_reg   <= rd_sim;
                    cur_steps_reg <= rd_steps;
                    cur_chk_reg   <= (rd_steps != 8'd0);
                    idx_reg       <= idx_reg + FW'(1);
                    state_reg     <= (rd_steps != 8'd0) ? ENT_DIV : WALK;
                end
                ENT_DIV: begin
                    state_reg <= ENT_WAIT;
                end
                ENT_WAIT: begin
                    if (!cur_chk_reg) begin
                        rate_num_reg <= {40'd0, sum_steps_reg} * {18'd0, RATE_SCALE};
                        state_reg    <= AVG_WAIT;
                        cur_chk_reg  <= 1'b1;
                        avg_reg      <= '0;
                    end else if (drsp.done) begin
                        if (drsp.quotient[31:0] > max_reg) begin
                            max_reg <= drsp.quotient[31:0];
                        end
                        if (idx_reg == fill_reg) begin
                            rate_num_reg <= {40'd0, sum_steps_reg} * {18'd0, RATE_SCALE};
                            avg_reg      <= '0;
                            state_reg    <= AVG_WAIT;
                        end else begin
                            state_reg <= WALK;
                        end
                    end
                end
                AVG_WAIT: begin
                    // The window average is being divided; a window without steps reads as zero.
                    if (drsp.done) begin
                        avg_reg   <= (sum_steps_reg != '0) ? drsp.quotient[31:0] : '0;
                        state_reg <= RATE_WAIT;
                    end
                end
                RATE_WAIT: begin
                    if (drsp.done) begin
                        if (sum_frame_reg == '0) begin
                            rate_reg <= '0;
                        end else if (drsp.quotient[63:24] != '0) begin
                            rate_reg <= RATE_MAX;
                        end else begin
                            rate_reg <= drsp.quotient[23:0];
                        end
                        state_reg <= LAST_WAIT;
                    end
                end
                LAST_WAIT: begin
                    if (drsp.done) begin
                        last_reg  <= (lsteps_reg != 8'd0) ? drsp.quotient[31:0] : '0;
                        state_reg <= OUT;
                    end
                end
                OUT: begin
                    out_valid_reg <= 1'b1;
                    o_fill_reg    <= fill_reg;
                    o_frames_reg  <= frames_reg;
                    o_steps_reg   <= steps_reg;
                    o_catch_reg   <= catch_reg;
                    o_limit_reg   <= limit_reg;
                    o_miss_reg    <= miss_reg;
                    o_flag_reg    <= flag_reg;
                    o_disc_reg    <= disc_reg;
                    o_last_reg    <= last_reg;
                    o_max_reg     <= max_reg;
                    o_avg_reg     <= avg_reg;
                    o_rate_reg    <= rate_reg;
                    state_reg     <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_window_fill        = o_fill_reg;
    assign m_frames_total       = o_frames_reg;
    assign m_steps_total        = o_steps_reg;
    assign m_catch_up_frames    = o_catch_reg;
    assign m_limit_hits         = o_limit_reg;
    assign m_deadline_misses    = o_miss_reg;
    assign m_last_missed        = o_flag_reg;
    assign m_last_step_ns       = o_last_reg;
    assign m_max_step_ns        = o_max_reg;
    assign m_avg_step_ns        = o_avg_reg;
    assign m_step_rate_q8       = o_rate_reg;
    assign m_discarded_total_ns = o_disc_reg;

endmodule

// ===== src/fstm_checker.sv =====
module fstm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [47:0] m_frames_total,
    input logic [47:0] m_deadline_misses,
    input logic        m_last_missed
);

    // A request is never taken in the cycle after another one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("back-to-back request accepted");

    // A result does not appear in the cycle after a request is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> !m_valid)
        else $error("result appeared too early");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_frames_total)))
        else $error("stalled result changed");

    // Misses never exceed frames, and a miss flag implies a miss count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_deadline_misses <= m_frames_total &&
                     (!m_last_missed || m_deadline_misses != 48'd0)))
        else $error("miss count inconsistent");

endmodule

bind fixed_step_timing_monitor fstm_checker u_fstm_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_frames_total(m_frames_total),
    .m_deadline_misses(m_deadline_misses), .m_last_missed(m_last_missed)
);
